>>> rtl/core/mmss_pkg.sv
// Shared constants, types and helpers for the motif mismatch scanner.
`timescale 1ns / 1ps
`default_nettype none

package mmss_pkg;

    localparam int MAX_MOTIF  = 32;
    localparam int IDX_W      = $clog2(MAX_MOTIF);
    localparam int LEN_W      = 6;
    localparam int LIMIT_W    = 4;
    localparam int MOTIF_W    = 2 * MAX_MOTIF;
    localparam int MISS_W     = $clog2(MAX_MOTIF + 1);
    localparam int GRP_SIZE   = 8;
    localparam int GRP_NUM    = MAX_MOTIF / GRP_SIZE;
    localparam int GRP_W      = $clog2(GRP_SIZE + 1);
    localparam int COUNT_BITS = 32;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_BASES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_LEN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = 2'd2;

    // Characters of interest
    localparam logic [7:0] CHAR_HEADER  = 8'h3E;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_T       = 8'h54;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SUM,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic       shift;
        logic       compare;
        logic       active;
        logic [1:0] want;
    } t_cell_ctl;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/motif_mismatch_scanner_unit.sv
// Top level of the motif mismatch scanner: window cells, counters and handshakes.
`timescale 1ns / 1ps
`default_nettype none

// Scans a nucleotide sequence file one byte per word and returns one result word for
// every input word. A, C, G and T bytes shift into a row of 32 window cells; the
// window is compared with the configured motif and counts as a match when the number
// of mismatching positions is at most the limit. From acceptance to a valid result:
// the accept cycle shifts the cells, the next registers each cell's mismatch flag,
// the next registers four group counts of the mismatch tree, and the last adds them,
// decides the match and updates the counters once the output register is free. A new
// word is taken once the previous one has moved into the output register.
// Headers ('>') and newlines update the line and sequence counters; all counters
// saturate. The user must write configuration only while no word is in flight; the
// block itself does not enforce it.
module motif_mismatch_scanner_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [mmss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [mmss_pkg::MOTIF_W-1:0]        i_cfg_wdata,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [7:0]                          i_text_byte,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_matched,
    output logic signed [mmss_pkg::OUT_W-1:0]        o_header_line,
    output logic [mmss_pkg::OUT_W-1:0]               o_match_number,
    output logic [mmss_pkg::OUT_W-1:0]               o_seq_pos,
    output logic [mmss_pkg::LIMIT_W-1:0]             o_mismatches,
    output logic [mmss_pkg::OUT_W-1:0]               o_total_matches,
    output logic [mmss_pkg::OUT_W-1:0]               o_seqs_with_match,
    output logic [mmss_pkg::OUT_W-1:0]               o_seqs_without_match
);

    // Configuration registers
    logic [mmss_pkg::MOTIF_W-1:0] r_motif;
    logic [mmss_pkg::LEN_W-1:0]   r_len;
    logic [mmss_pkg::LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif <= '0;
            r_len   <= mmss_pkg::LEN_W'(1);
            r_limit <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                mmss_pkg::CFG_MOTIF_BASES:    r_motif <= i_cfg_wdata;
                mmss_pkg::CFG_MOTIF_LEN:      r_len   <= i_cfg_wdata[mmss_pkg::LEN_W-1:0];
                mmss_pkg::CFG_MISMATCH_LIMIT: r_limit <= i_cfg_wdata[mmss_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input decode
    logic       w_in_acc;
    logic       w_is_base;
    logic [1:0] w_code;

    always_comb begin
        w_is_base = 1'b1;
        unique case (i_text_byte)
            mmss_pkg::CHAR_A: w_code = mmss_pkg::BASE_A;
            mmss_pkg::CHAR_C: w_code = mmss_pkg::BASE_C;
            mmss_pkg::CHAR_G: w_code = mmss_pkg::BASE_G;
            mmss_pkg::CHAR_T: w_code = mmss_pkg::BASE_T;
            default: begin
                w_code    = mmss_pkg::BASE_A;
                w_is_base = 1'b0;
            end
        endcase
    end

    // Control
    mmss_pkg::t_state r_state;
    mmss_pkg::t_state n_state;
    logic             w_done;
    logic             w_out_free;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        w_done  = 1'b0;
        unique case (r_state)
            mmss_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = mmss_pkg::ST_CMP;
                end
            end
            mmss_pkg::ST_CMP: n_state = mmss_pkg::ST_SUM;
            mmss_pkg::ST_SUM: n_state = mmss_pkg::ST_UPD;
            mmss_pkg::ST_UPD: begin
                if (w_out_free) begin
                    w_done  = 1'b1;
                    n_state = mmss_pkg::ST_IDLE;
                end
            end
            default: n_state = mmss_pkg::ST_IDLE;
        endcase
    end

    // Byte class of the word in flight
    logic r_is_base;
    logic r_is_nl;
    logic r_is_hdr;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_is_base <= w_is_base;
            r_is_nl   <= (i_text_byte == mmss_pkg::CHAR_NEWLINE);
            r_is_hdr  <= (i_text_byte == mmss_pkg::CHAR_HEADER);
        end
    end

    // Effective motif length, clamped to 1..MAX_MOTIF
    logic [mmss_pkg::LEN_W-1:0] w_len_eff;

    always_comb begin
        if (r_len == '0) begin
            w_len_eff = mmss_pkg::LEN_W'(1);
        end else if (r_len > mmss_pkg::LEN_W'(mmss_pkg::MAX_MOTIF)) begin
            w_len_eff = mmss_pkg::LEN_W'(mmss_pkg::MAX_MOTIF);
        end else begin
            w_len_eff = r_len;
        end
    end

    // Row of window cells; cell a holds the base that entered a bases before the newest and
    // meets motif base len-1-a.
    mmss_pkg::t_cell_ctl          w_ctl  [mmss_pkg::MAX_MOTIF];
    logic [mmss_pkg::IDX_W-1:0]   w_sel  [mmss_pkg::MAX_MOTIF];
    logic [1:0]                   w_base [mmss_pkg::MAX_MOTIF];
    logic                         w_fill [mmss_pkg::MAX_MOTIF];
    logic [mmss_pkg::MAX_MOTIF-1:0] w_miss;

    always_comb begin
        for (int a = 0; a < mmss_pkg::MAX_MOTIF; a++) begin
            w_sel[a]          = mmss_pkg::IDX_W'(w_len_eff - mmss_pkg::LEN_W'(1)
                                                 - mmss_pkg::LEN_W'(a));
            w_ctl[a].shift    = w_in_acc && w_is_base;
            w_ctl[a].compare  = (r_state == mmss_pkg::ST_CMP);
            w_ctl[a].active   = (mmss_pkg::LEN_W'(a) < w_len_eff);
            w_ctl[a].want     = r_motif[{w_sel[a], 1'b0} +: 2];
        end
    end

    for (genvar a = 0; a < mmss_pkg::MAX_MOTIF; a++) begin : g_cell
        if (a == 0) begin : g_head
            mmss_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl[a]),
                .i_base   (w_code),
                .i_filled (1'b1),
                .o_base   (w_base[a]),
                .o_filled (w_fill[a]),
                .o_miss   (w_miss[a])
            );
        end else begin : g_body
            mmss_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl[a]),
                .i_base   (w_base[a-1]),
                .i_filled (w_fill[a-1]),
                .o_base   (w_base[a]),
                .o_filled (w_fill[a]),
                .o_miss   (w_miss[a])
            );
        end
    end

    logic [mmss_pkg::MISS_W-1:0] w_miss_cnt;

    mmss_popcnt u_popcnt (
        .i_clk   (i_clk),
        .i_en    (r_state == mmss_pkg::ST_SUM),
        .i_bits  (w_miss),
        .o_count (w_miss_cnt)
    );

    // Counters
    logic [mmss_pkg::COUNT_BITS-1:0] r_line;
    logic [mmss_pkg::COUNT_BITS-1:0] r_hdr_line;
    logic [mmss_pkg::COUNT_BITS-1:0] r_seq_match;
    logic [mmss_pkg::COUNT_BITS-1:0] r_pos;
    logic [mmss_pkg::COUNT_BITS-1:0] r_total;
    logic [mmss_pkg::COUNT_BITS-1:0] r_pos_seqs;
    logic [mmss_pkg::COUNT_BITS-1:0] r_neg_seqs;
    logic [mmss_pkg::COUNT_BITS-1:0] n_line;
    logic [mmss_pkg::COUNT_BITS-1:0] n_hdr_line;
    logic [mmss_pkg::COUNT_BITS-1:0] n_seq_match;
    logic [mmss_pkg::COUNT_BITS-1:0] n_pos;
    logic [mmss_pkg::COUNT_BITS-1:0] n_total;
    logic [mmss_pkg::COUNT_BITS-1:0] n_pos_seqs;
    logic [mmss_pkg::COUNT_BITS-1:0] n_neg_seqs;
    logic                            w_hit;

    assign w_hit = r_is_base
                && (w_miss_cnt <= mmss_pkg::MISS_W'(r_limit));

    always_comb begin
        n_line      = r_line;
        n_hdr_line  = r_hdr_line;
        n_seq_match = r_seq_match;
        n_pos       = r_pos;
        n_total     = r_total;
        n_pos_seqs  = r_pos_seqs;
        n_neg_seqs  = r_neg_seqs;
        if (r_is_nl) begin
            n_line = mmss_pkg::sat_inc(r_line);
        end
        // A header closes the previous sequence; the very first one closes an
        // empty sequence that never matched.
        if (r_is_hdr) begin
            n_hdr_line  = r_line;
            n_seq_match = '0;
            n_pos       = '0;
            if (r_seq_match == '0) begin
                n_neg_seqs = mmss_pkg::sat_inc(r_neg_seqs);
            end
        end
        if (r_is_base) begin
            n_pos = mmss_pkg::sat_inc(r_pos);
        end
        if (w_hit) begin
            n_seq_match = mmss_pkg::sat_inc(r_seq_match);
            n_total     = mmss_pkg::sat_inc(r_total);
            if (r_seq_match == '0) begin
                n_pos_seqs = mmss_pkg::sat_inc(r_pos_seqs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= mmss_pkg::COUNT_BITS'(1);
            r_hdr_line  <= '1;
            r_seq_match <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_pos_seqs  <= '0;
            r_neg_seqs  <= '0;
        end else if (w_done) begin
            r_line      <= n_line;
            r_hdr_line  <= n_hdr_line;
            r_seq_match <= n_seq_match;
            r_pos       <= n_pos;
            r_total     <= n_total;
            r_pos_seqs  <= n_pos_seqs;
            r_neg_seqs  <= n_neg_seqs;
        end
    end

    // Output register
    logic                          r_out_valid;
    logic                          r_out_matched;
    logic [mmss_pkg::OUT_W-1:0]    r_out_hdr;
    logic [mmss_pkg::OUT_W-1:0]    r_out_seq_match;
    logic [mmss_pkg::OUT_W-1:0]    r_out_pos;
    logic [mmss_pkg::LIMIT_W-1:0]  r_out_miss;
    logic [mmss_pkg::OUT_W-1:0]    r_out_total;
    logic [mmss_pkg::OUT_W-1:0]    r_out_pos_seqs;
    logic [mmss_pkg::OUT_W-1:0]    r_out_neg_seqs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_matched   <= w_hit;
            r_out_hdr       <= n_hdr_line[mmss_pkg::OUT_W-1:0];
            r_out_seq_match <= n_seq_match[mmss_pkg::OUT_W-1:0];
            r_out_pos       <= n_pos[mmss_pkg::OUT_W-1:0];
            r_out_miss      <= w_hit ? w_miss_cnt[mmss_pkg::LIMIT_W-1:0] : '0;
            r_out_total     <= n_total[mmss_pkg::OUT_W-1:0];
            r_out_pos_seqs  <= n_pos_seqs[mmss_pkg::OUT_W-1:0];
            r_out_neg_seqs  <= n_neg_seqs[mmss_pkg::OUT_W-1:0];
        end
    end

    assign o_valid              = r_out_valid;
    assign o_matched            = r_out_matched;
    assign o_header_line        = $signed(r_out_hdr);
    assign o_match_number       = r_out_seq_match;
    assign o_seq_pos            = r_out_pos;
    assign o_mismatches         = r_out_miss;
    assign o_total_matches      = r_out_total;
    assign o_seqs_with_match    = r_out_pos_seqs;
    assign o_seqs_without_match = r_out_neg_seqs;

    // Assertions
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_stall)
        else $error("input accepted while a word was still in flight");

    a_hit_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_matched) |-> (o_mismatches <= r_limit))
        else $error("reported match exceeds the mismatch limit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_matched) |-> (o_mismatches == '0))
        else $error("mismatch count reported without a match");

    a_valid_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == mmss_pkg::ST_UPD))
        else $error("result appeared outside the update step");

endmodule

`default_nettype wire

>>> rtl/core/mmss_cell.sv
// One window slot: holds a base and its filled flag, and flags a mismatch.
`timescale 1ns / 1ps
`default_nettype none

module mmss_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mmss_pkg::t_cell_ctl i_ctl,
    input  wire logic [1:0]          i_base,
    input  wire logic                i_filled,
    output logic [1:0]               o_base,
    output logic                     o_filled,
    output logic                     o_miss
);

    logic [1:0] r_base;
    logic       r_filled;
    logic       r_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_filled <= 1'b0;
            r_miss   <= 1'b0;
        end else begin
            if (i_ctl.shift) begin
                r_base   <= i_base;
                r_filled <= i_filled;
            end
            // An empty slot never matches a motif base.
            if (i_ctl.compare) begin
                r_miss <= i_ctl.active && (!r_filled || (r_base != i_ctl.want));
            end
        end
    end

    assign o_base   = r_base;
    assign o_filled = r_filled;
    assign o_miss   = r_miss;

endmodule

`default_nettype wire

>>> rtl/core/mmss_popcnt.sv
// Two-level mismatch counter: registered group counts, then their sum.
`timescale 1ns / 1ps
`default_nettype none

module mmss_popcnt (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [mmss_pkg::MAX_MOTIF-1:0]  i_bits,
    output logic [mmss_pkg::MISS_W-1:0]          o_count
);

    logic [mmss_pkg::GRP_W-1:0] r_grp [mmss_pkg::GRP_NUM];
    logic [mmss_pkg::GRP_W-1:0] n_grp [mmss_pkg::GRP_NUM];

    always_comb begin
        for (int g = 0; g < mmss_pkg::GRP_NUM; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < mmss_pkg::GRP_SIZE; b++) begin
                n_grp[g] = n_grp[g]
                         + mmss_pkg::GRP_W'(i_bits[g * mmss_pkg::GRP_SIZE + b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_count = '0;
        for (int g = 0; g < mmss_pkg::GRP_NUM; g++) begin
            o_count = o_count + mmss_pkg::MISS_W'(r_grp[g]);
        end
    end

endmodule

`default_nettype wire
